FILE: hdl/hse_pkg.sv
// shared types, codes and defaults for the hash set engine
package hse_pkg;

  // default geometry of the slot store
  localparam int unsigned BUCKETS_DEF = 1024;
  localparam int unsigned WAYS_DEF    = 4;

  // key width and widest bucket index the geometry range allows
  localparam int unsigned KEY_W = 32;
  localparam int unsigned BKT_W = 20;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // request item
  typedef struct packed {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key;
  } req_t;

  // result item
  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bucket;
  } job_t;

endpackage

FILE: hdl/hse_ram.sv
// generic single-write, single-read ram with registered read data
module hse_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/hse_front.sv
// front end: takes items and works out the bucket of each key
module hse_front #(
  parameter int unsigned BUCKETS = hse_pkg::BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  hse_pkg::req_t req_i,
  input  logic          full_i,
  output logic          push_o,
  output hse_pkg::job_t job_o,
  output logic          busy_o
);

  localparam int unsigned BW      = $clog2(BUCKETS);
  localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic [hse_pkg::KEY_W-1:0] key_raw;
  logic [hse_pkg::KEY_W-1:0] key_mag;

  // magnitude of the key, most negative value included
  assign key_raw = req_i.key;
  assign key_mag = key_raw[hse_pkg::KEY_W-1] ? (~key_raw + 32'd1) : key_raw;

  if (IS_POW2) begin : g_mask
    // bucket is the low bits of the magnitude
    assign push_o       = take_i;
    assign busy_o       = full_i;
    assign job_o.mode   = req_i.mode;
    assign job_o.key    = key_raw;
    assign job_o.bucket = hse_pkg::BKT_W'(key_mag[BW-1:0]);
  end else begin : g_recip
    // fixed reciprocal of the bucket count, exact for every 32-bit magnitude
    localparam int unsigned     SH      = hse_pkg::KEY_W + BW;
    localparam int unsigned     RW      = hse_pkg::KEY_W + 1;
    localparam int unsigned     PW      = 2 * hse_pkg::KEY_W + 1;
    localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_QUO  = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]                state_q, state_d;
    logic [hse_pkg::KEY_W-1:0] mag_q, mag_d;
    logic [hse_pkg::KEY_W-1:0] quo_q, quo_d;
    logic [BW-1:0]             rem_q, rem_d;
    logic [1:0]                mode_q, mode_d;
    logic [hse_pkg::KEY_W-1:0] key_q, key_d;
    logic [PW-1:0]             prod;
    logic [hse_pkg::KEY_W-1:0] scaled;

    // quotient by the reciprocal, then the quotient times the bucket count
    assign prod   = PW'(mag_q) * PW'(RECIP);
    assign scaled = quo_q * hse_pkg::KEY_W'(BUCKETS);

    always_comb begin
      state_d = state_q;
      mag_d   = mag_q;
      quo_d   = quo_q;
      rem_d   = rem_q;
      mode_d  = mode_q;
      key_d   = key_q;
      unique case (state_q)
        S_IDLE: begin
          if (take_i) begin
            mode_d  = req_i.mode;
            key_d   = key_raw;
            mag_d   = key_mag;
            state_d = S_QUO;
          end
        end
        S_QUO: begin
          quo_d   = hse_pkg::KEY_W'(prod >> SH);
          state_d = S_REM;
        end
        S_REM: begin
          rem_d   = BW'(mag_q - scaled);
          state_d = S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) begin
            state_d = S_IDLE;
          end
        end
      endcase
    end

    // control state
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        state_q <= S_IDLE;
      end else begin
        state_q <= state_d;
      end
    end

    // item payload and remainder datapath
    always_ff @(posedge clk_i) begin
      mag_q  <= mag_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      mode_q <= mode_d;
      key_q  <= key_d;
    end

    assign busy_o       = (state_q != S_IDLE);
    assign push_o       = (state_q == S_PUSH) && !full_i;
    assign job_o.mode   = mode_q;
    assign job_o.key    = key_q;
    assign job_o.bucket = hse_pkg::BKT_W'(rem_q);
  end

endmodule

FILE: hdl/hse_fifo.sv
// two-entry queue between the front and back ends
module hse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hse_pkg::job_t job_i,
  input  logic          pop_i,
  output hse_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  hse_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

FILE: hdl/hse_back.sv
// back end: bucket row read, parallel slot compare and row write-back
module hse_back #(
  parameter int unsigned BUCKETS = hse_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hse_pkg::WAYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hse_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output hse_pkg::rsp_t rsp_o
);

  localparam int unsigned AW    = $clog2(BUCKETS);
  localparam int unsigned KW    = hse_pkg::KEY_W;
  localparam int unsigned ROW_W = WAYS * (KW + 1);

  localparam logic [1:0] SB_CLEAR = 2'd0;
  localparam logic [1:0] SB_IDLE  = 2'd1;
  localparam logic [1:0] SB_LOOK  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  hse_pkg::job_t cur_q;
  logic          done_q;
  hse_pkg::rsp_t rsp_q, rsp_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;
  logic [ROW_W-1:0] rdata;

  logic [WAYS-1:0]    rd_valid, hit, hit_first, free_first, new_valid;
  logic [WAYS*KW-1:0] rd_keys, new_keys;
  logic               found;

  // row store: valid bits on top, keys below
  hse_ram #(
    .W(ROW_W),
    .D(BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(job_i.bucket[AW-1:0]),
    .rdata_o(rdata)
  );

  assign rd_valid = rdata[ROW_W-1 -: WAYS];
  assign rd_keys  = rdata[WAYS*KW-1:0];

  // compare every slot of the row at once
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = rd_valid[w] && (rd_keys[w*KW +: KW] == cur_q.key);
    end
  end

  // lowest hit and lowest free slot
  assign hit_first  = hit & (~hit + WAYS'(1));
  assign free_first = ~rd_valid & (rd_valid + WAYS'(1));
  assign found      = |hit;

  // updated row and result
  always_comb begin
    new_valid    = rd_valid;
    new_keys     = rd_keys;
    rsp_d.found  = found;
    rsp_d.status = hse_pkg::ST_NOCHANGE;
    case (cur_q.mode)
      hse_pkg::MODE_INSERT: begin
        if (found) begin
          rsp_d.status = hse_pkg::ST_NOCHANGE;
        end else if (&rd_valid) begin
          rsp_d.status = hse_pkg::ST_FULL;
        end else begin
          rsp_d.status = hse_pkg::ST_DONE;
          new_valid    = rd_valid | free_first;
          for (int w = 0; w < WAYS; w++) begin
            if (free_first[w]) begin
              new_keys[w*KW +: KW] = cur_q.key;
            end
          end
        end
      end
      hse_pkg::MODE_DELETE: begin
        if (found) begin
          rsp_d.status = hse_pkg::ST_DONE;
          new_valid    = rd_valid & ~hit_first;
        end
      end
      hse_pkg::MODE_QUERY: begin
        rsp_d.status = hse_pkg::ST_DONE;
      end
      default: begin
        rsp_d.status = hse_pkg::ST_NOCHANGE;
      end
    endcase
  end

  // sequencer: clearing pass, then read and write-back per item
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = cur_q.bucket[AW-1:0];
    wdata   = {new_valid, new_keys};
    unique case (state_q)
      SB_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(BUCKETS - 1)) begin
          state_d = SB_IDLE;
        end
      end
      SB_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = SB_LOOK;
        end
      end
      SB_LOOK: begin
        we      = 1'b1;
        state_d = SB_IDLE;
      end
      default: begin
        state_d = SB_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SB_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == SB_LOOK);
    end
  end

  // current item and result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (state_q == SB_LOOK) begin
      rsp_q <= rsp_d;
    end
  end

  assign clearing_o = (state_q == SB_CLEAR);
  assign done_o     = done_q;
  assign rsp_o      = rsp_q;

endmodule

FILE: hdl/hash_set_engine.sv
// top level of the hash set engine: front end, queue and back end
//
// Set of signed 32-bit keys in BUCKETS rows of WAYS slots. An item is taken
// when start is high and busy is low; every item gives one result on rsp_o,
// marked by done_o for a single cycle, which must be taken as it comes.
// After reset the block holds busy high while it clears the slot store one
// row a cycle. The back end reads the bucket row, then compares and writes
// it back, and takes no new item until the last one is written back. When
// BUCKETS is a power of two the front end passes each item straight to the
// queue and takes a new one whenever the queue is not full. For other
// bucket counts the front end finds the bucket by multiplying the key
// magnitude by a fixed reciprocal of BUCKETS and subtracting the quotient
// times BUCKETS, in a quotient, a remainder and a push state before the
// item reaches the queue; it takes no new item until the last is pushed.
module hash_set_engine #(
  parameter int unsigned BUCKETS = hse_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hse_pkg::WAYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hse_pkg::req_t req_i,
  output logic          done_o,
  output hse_pkg::rsp_t rsp_o
);

  logic          take;
  logic          front_busy;
  logic          clearing;
  logic          push, pop, empty, full;
  hse_pkg::job_t push_job, head_job;

  // items are refused while clearing or while the front end is busy
  assign busy = front_busy || clearing;
  assign take = start && !busy;

  hse_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .req_i (req_i),
    .full_i(full),
    .push_o(push),
    .job_o (push_job),
    .busy_o(front_busy)
  );

  hse_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .empty_o(empty),
    .full_o (full)
  );

  hse_back #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .empty_i   (empty),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

  // queue never takes an item when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue overflow");

  // the back end never gives results in adjacent cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("results in adjacent cycles");

  // no result during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !done_o)
    else $error("result while clearing");

  // a refused insert never reports the key present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == hse_pkg::ST_FULL)) |-> !rsp_o.found)
    else $error("full bucket with key present");

endmodule

FILE: tb/sv/hse_checker.sv
// checker for the hash set engine: predicts each item's result and compares
module hse_checker #(
  parameter int unsigned BUCKETS = hse_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hse_pkg::WAYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  hse_pkg::req_t req_i,
  input  logic          done_i,
  input  hse_pkg::rsp_t rsp_i,
  output int            fail_cnt_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  // shadow copy of the slot store
  logic [KEY_W-1:0] shadow_key   [BUCKETS*WAYS];
  bit               shadow_valid [BUCKETS*WAYS];

  // results owed by the block, oldest first
  rsp_t owed_rsp_q[$];

  // apply one set operation to the shadow store and return its result
  function automatic rsp_t apply_set_op(req_t r);
    longint signed k;
    longint signed rem;
    int unsigned   base;
    int            hit_way;
    int            free_way;
    rsp_t          res;
    k        = longint'($signed(r.key));
    rem      = k % longint'(BUCKETS);
    if (rem < 0) rem = -rem;
    base     = int'(rem) * WAYS;
    hit_way  = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit_way < 0 && shadow_key[base + w] == r.key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res.found = (hit_way >= 0);
    case (r.mode)
      MODE_INSERT: begin
        if (hit_way >= 0) begin
          res.status = ST_NOCHANGE;
        end else if (free_way < 0) begin
          res.status = ST_FULL;
        end else begin
          shadow_key[base + free_way]   = r.key;
          shadow_valid[base + free_way] = 1'b1;
          res.status = ST_DONE;
        end
      end
      MODE_DELETE: begin
        if (hit_way >= 0) begin
          shadow_valid[base + hit_way] = 1'b0;
          res.status = ST_DONE;
        end else begin
          res.status = ST_NOCHANGE;
        end
      end
      MODE_QUERY: res.status = ST_DONE;
      default:    res.status = ST_NOCHANGE;
    endcase
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    bit   bad;
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS*WAYS; i++) shadow_valid[i] = 1'b0;
      owed_rsp_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (start_i && !busy_i) owed_rsp_q.push_back(apply_set_op(req_i));
      if (done_i) begin
        if (owed_rsp_q.size() == 0) begin
          $display("%0t: result with none owed: found=%0d status=%0d",
                   $time, rsp_i.found, rsp_i.status);
          fail_cnt_o++;
        end else begin
          want = owed_rsp_q.pop_front();
          bad  = 1'b0;
          if (rsp_i.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d",
                     $time, want.found, rsp_i.found);
            bad = 1'b1;
          end
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_i.status);
            bad = 1'b1;
          end
          if (bad) fail_cnt_o++;
        end
      end
      pending_o = owed_rsp_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top for the hash set engine: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  // mode value the block does not define
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned BKTS        = BUCKETS_DEF;
  localparam int          STALL_LIMIT = 4 * BKTS + 500;
  localparam int          RAND_ITEMS  = 600;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  int   fail_cnt;
  int   pending;
  int   stall_cycles;
  bit   gaps_on;

  // keys recently inserted, reused so deletes and queries hit
  logic [KEY_W-1:0] recent_keys[$];

  hash_set_engine #(.BUCKETS(BKTS), .WAYS(WAYS_DEF)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  hse_checker #(.BUCKETS(BKTS), .WAYS(WAYS_DEF)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done),
    .rsp_i      (rsp),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one item, after a random gap when gaps are on, and hold it until taken
  task automatic send_op(logic [1:0] mode, logic [KEY_W-1:0] key);
    int gap;
    req_t r;
    gap    = gaps_on ? $urandom_range(8, 0) : 0;
    r.mode = mode;
    r.key  = key;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (mode == MODE_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  // key biased toward a few crowded buckets so rows fill up
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    int unsigned      row;
    int unsigned      mult;
    logic [KEY_W-1:0] mag;
    sel = $urandom_range(9, 0);
    if (sel == 0) return $urandom();
    if (sel < 3 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
    row = $urandom_range(11, 0);
    if (row >= 8) row = BKTS - 1 - (row - 8);
    mult = (sel == 9) ? $urandom_range(2097151, 0) : $urandom_range(7, 0);
    mag  = KEY_W'(row) + KEY_W'(mult) * KEY_W'(BKTS);
    return $urandom_range(1, 0) ? (~mag + KEY_W'(1)) : mag;
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 40) return MODE_INSERT;
    if (roll < 65) return MODE_DELETE;
    if (roll < 90) return MODE_QUERY;
    return MODE_UNUSED;
  endfunction

  // stimulus and verdict
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req          = '0;
    gaps_on      = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero key, duplicate insert
    send_op(MODE_INSERT, 32'd0);
    send_op(MODE_QUERY,  32'd0);
    send_op(MODE_INSERT, 32'd0);
    // field extremes: most negative lands in row zero, max and near-min in the last row
    send_op(MODE_INSERT, 32'h8000_0000);
    send_op(MODE_INSERT, 32'h7fff_ffff);
    send_op(MODE_INSERT, 32'h8000_0001);
    send_op(MODE_QUERY,  32'h8000_0001);
    send_op(MODE_DELETE, 32'hffff_ffff);
    // fill one row with both signs, then overflow it
    send_op(MODE_INSERT, 32'd5);
    send_op(MODE_INSERT, -32'sd5);
    send_op(MODE_INSERT, 32'd1029);
    send_op(MODE_INSERT, -32'sd1029);
    send_op(MODE_INSERT, 32'd2053);
    send_op(MODE_QUERY,  32'd2053);
    // free a slot and reuse it
    send_op(MODE_DELETE, -32'sd5);
    send_op(MODE_INSERT, 32'd2053);
    send_op(MODE_QUERY,  -32'sd5);
    send_op(MODE_DELETE, 32'd7);
    // undefined mode, present and absent key
    send_op(MODE_UNUSED, 32'd5);
    send_op(MODE_UNUSED, 32'd6);
    send_op(MODE_DELETE, 32'd0);
    send_op(MODE_QUERY,  32'd0);
    send_op(MODE_INSERT, 32'h8000_0000);

    // random traffic, with stretches of back-to-back items
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(39, 0) == 0) gaps_on = !gaps_on;
      send_op(pick_mode(), pick_key());
    end
    start <= 1'b0;

    // drain outstanding results, then a few quiet cycles
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
